>>> hdl/slave_clock_hand_positioner_defines.svh
// Assertion macros for the slave clock hand positioner.
// Used by the top level; expects signals clk and arst_n in scope.
`ifndef SLAVE_CLOCK_HAND_POSITIONER_DEFINES_SVH
`define SLAVE_CLOCK_HAND_POSITIONER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SCHP_ASSERT_IMP(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("schp: same-cycle check failed");

// next-cycle implication, checked outside reset
`define SCHP_ASSERT_NXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("schp: next-cycle check failed");

`endif

>>> hdl/schp_pkg.sv
// Shared types, codes and constants of the slave clock hand positioner.
// No dependencies.
package schp_pkg;

	// field widths
	localparam int HourW    = 4;
	localparam int MinW     = 6;
	localparam int RtcHourW = 5;
	localparam int StepW    = 10;
	localparam int MsW      = 16;
	localparam int CfgIdxW  = 2;

	// dial arithmetic, minute counts fit 11 bits before folding
	localparam int DialW    = 11;
	localparam int DialMin  = 60;
	localparam int DialSpan = 720;
	localparam int MsPerMin = 60000;
	localparam int WaitW    = 26;
	localparam int RunW     = 27;

	// reset values
	localparam logic [MsW-1:0]   PulseMsRst      = 16'd4000;
	localparam logic [MsW-1:0]   AfterPulseMsRst = 16'd0;
	localparam logic [HourW-1:0] HourRst         = 4'd12;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_PULSE_MS       = 2'd0,
		CFG_AFTER_PULSE_MS = 2'd1,
		CFG_MOTOR_BLOCK    = 2'd2
	} cfg_idx_t;

	// input operation codes
	typedef enum logic [2:0] {
		OP_MOVE  = 3'd0,
		OP_STEP  = 3'd1,
		OP_RTC   = 3'd2,
		OP_STOP  = 3'd3,
		OP_START = 3'd4
	} op_t;

	// output mode codes
	localparam logic [1:0] MODE_READY = 2'd0;
	localparam logic [1:0] MODE_WAIT  = 2'd1;
	localparam logic [1:0] MODE_MOVE  = 2'd2;
	localparam logic [1:0] MODE_STOP  = 2'd3;

	// one-hot mode state
	typedef enum logic [3:0] {
		ST_READY = 4'b0001,
		ST_WAIT  = 4'b0010,
		ST_MOVE  = 4'b0100,
		ST_STOP  = 4'b1000
	} mode_st_t;

	typedef struct packed {
		logic [MsW-1:0] pulse_ms;
		logic [MsW-1:0] after_pulse_ms;
		logic           motor_block;
	} cfg_t;

	typedef struct packed {
		logic [HourW-1:0] hours;
		logic [MinW-1:0]  minutes;
	} dial_t;

	typedef struct packed {
		logic [StepW-1:0] fwd;
		logic             at_target;
		logic             wait_rtc;
	} plan_t;

	typedef struct packed {
		op_t                 op;
		logic [HourW-1:0]    target_hours;
		logic [MinW-1:0]     target_minutes;
		logic [RtcHourW-1:0] rtc_hours;
		logic [MinW-1:0]     rtc_minutes;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       mode;
		logic             pulse_a;
		logic             pulse_b;
		logic [HourW-1:0] dial_hours;
		logic [MinW-1:0]  dial_minutes;
		logic             pulse_polarity;
		logic [StepW-1:0] steps_left;
		logic             move_done;
	} res_t;

	// output code of a mode state
	function automatic logic [1:0] mode_code(mode_st_t st);
		logic [1:0] code;
		case (st)
			ST_READY: code = MODE_READY;
			ST_WAIT:  code = MODE_WAIT;
			ST_MOVE:  code = MODE_MOVE;
			ST_STOP:  code = MODE_STOP;
			default:  code = MODE_READY;
		endcase
		return code;
	endfunction

endpackage

>>> hdl/slave_clock_hand_positioner.sv
// Slave clock hand positioner: takes one input word per cycle unless stalled and returns
// one result word for it in the cycle after acceptance, from a single output
// register. s_axis_tready is high whenever that register is empty or is
// being taken in the same cycle, so with m_axis_tready held high one word
// is accepted every clock; the update of the dial state is one pass of
// logic between that state and the output register. The configuration
// port is always ready and a write takes effect from the next word on.
// Depends on schp_pkg, schp_cfg_regs, schp_core and the assertion macro header.
`include "slave_clock_hand_positioner_defines.svh"

module slave_clock_hand_positioner (
	input  logic                         clk,
	input  logic                         arst_n,
	// input words
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// [3:0] target_hours, [9:4] target_minutes, [14:10] rtc_hours,
	// [20:15] rtc_minutes, [23:21] zero
	input  logic [23:0]                  s_axis_tdata,
	// [2:0] op
	input  logic [2:0]                   s_axis_tuser,
	// result words
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [1:0] mode, [2] pulse_a, [3] pulse_b, [7:4] dial_hours,
	// [13:8] dial_minutes, [14] pulse_polarity, [24:15] steps_left,
	// [25] move_done, [31:26] zero
	output logic [31:0]                  m_axis_tdata,
	// configuration writes
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [schp_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [schp_pkg::MsW-1:0]     cfg_data
);

	schp_pkg::cfg_t     cfg;
	schp_pkg::in_item_t item;
	schp_pkg::res_t     res, res_q;
	logic               out_valid_q;
	logic               in_accept;

	assign cfg_ready = 1'b1;

	schp_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// unpack the input word
	always_comb begin
		item.op             = schp_pkg::op_t'(s_axis_tuser);
		item.target_hours   = s_axis_tdata[3:0];
		item.target_minutes = s_axis_tdata[9:4];
		item.rtc_hours      = s_axis_tdata[14:10];
		item.rtc_minutes    = s_axis_tdata[20:15];
	end

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	schp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (in_accept),
		.item   (item),
		.cfg    (cfg),
		.res    (res)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s_axis_tready)
			out_valid_q <= s_axis_tvalid;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (in_accept)
			res_q <= res;
	end

	// pack the result word
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, res_q.move_done, res_q.steps_left, res_q.pulse_polarity,
	                        res_q.dial_minutes, res_q.dial_hours, res_q.pulse_b,
	                        res_q.pulse_a, res_q.mode};

	// a held result blocks new input only while it is stalled
	`SCHP_ASSERT_IMP(a_ready_stall, !s_axis_tready, out_valid_q && !m_axis_tready)
	// every accepted word shows a result in the next cycle
	`SCHP_ASSERT_NXT(a_accept_result, in_accept, m_axis_tvalid)
	// pulses come only from steps, which leave the block moving or ready
	`SCHP_ASSERT_IMP(a_pulse_mode, out_valid_q && (res_q.pulse_a || res_q.pulse_b),
		!(res_q.pulse_a && res_q.pulse_b) &&
		(res_q.mode == schp_pkg::MODE_MOVE || res_q.mode == schp_pkg::MODE_READY))

endmodule

>>> hdl/schp_cfg_regs.sv
// Configuration registers of the slave clock hand positioner.
// Depends on schp_pkg.
module schp_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [schp_pkg::CfgIdxW-1:0]  wr_index,
	input  logic [schp_pkg::MsW-1:0]      wr_data,
	output schp_pkg::cfg_t                cfg
);

	schp_pkg::cfg_t cfg_q;

	// register write, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_ms       <= schp_pkg::PulseMsRst;
			cfg_q.after_pulse_ms <= schp_pkg::AfterPulseMsRst;
			cfg_q.motor_block    <= 1'b0;
		end else if (wr_en) begin
			case (schp_pkg::cfg_idx_t'(wr_index))
				schp_pkg::CFG_PULSE_MS:       cfg_q.pulse_ms       <= wr_data;
				schp_pkg::CFG_AFTER_PULSE_MS: cfg_q.after_pulse_ms <= wr_data;
				schp_pkg::CFG_MOTOR_BLOCK:    cfg_q.motor_block    <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hdl/schp_move_plan.sv
// Move planner: forward distance and wait-or-step decision for a move command.
// Depends on schp_pkg.
module schp_move_plan (
	input  schp_pkg::dial_t                  dial,
	input  logic [schp_pkg::HourW-1:0]       target_hours,
	input  logic [schp_pkg::MinW-1:0]        target_minutes,
	input  schp_pkg::cfg_t                   cfg,
	output schp_pkg::plan_t                  plan
);

	localparam logic [schp_pkg::DialW-1:0] Min  = schp_pkg::DialW'(schp_pkg::DialMin);
	localparam logic [schp_pkg::DialW-1:0] Span = schp_pkg::DialW'(schp_pkg::DialSpan);

	logic [schp_pkg::DialW-1:0] cur_raw, end_raw, cur, tgt, fwd_raw, back_raw;
	logic [schp_pkg::StepW-1:0] fwd, back;
	logic [schp_pkg::MsW:0]     per_step_ms;
	logic [schp_pkg::WaitW-1:0] wait_ms;
	logic [schp_pkg::RunW-1:0]  run_ms;

	// dial positions in minutes, folded once into one turn
	always_comb begin
		cur_raw = schp_pkg::DialW'(dial.hours) * Min + schp_pkg::DialW'(dial.minutes);
		end_raw = schp_pkg::DialW'(target_hours) * Min + schp_pkg::DialW'(target_minutes);
		cur     = (cur_raw >= Span) ? cur_raw - Span : cur_raw;
		tgt     = (end_raw >= Span) ? end_raw - Span : end_raw;
	end

	// forward and backward distances modulo one turn
	always_comb begin
		fwd_raw  = tgt + Span - cur;
		back_raw = cur + Span - tgt;
		fwd      = schp_pkg::StepW'((fwd_raw >= Span) ? fwd_raw - Span : fwd_raw);
		back     = schp_pkg::StepW'((back_raw >= Span) ? back_raw - Span : back_raw);
	end

	// waiting time against stepping time, both in ms
	always_comb begin
		per_step_ms = {1'b0, cfg.pulse_ms} + {1'b0, cfg.after_pulse_ms};
		wait_ms     = schp_pkg::WaitW'(back) * schp_pkg::WaitW'(schp_pkg::MsPerMin);
		run_ms      = schp_pkg::RunW'(fwd) * schp_pkg::RunW'(per_step_ms);
	end

	assign plan.fwd       = fwd;
	assign plan.at_target = (fwd == '0);
	assign plan.wait_rtc  = ({1'b0, wait_ms} <= run_ms);

endmodule

>>> hdl/schp_core.sv
// Dial state and per-word update of the slave clock hand positioner.
// Depends on schp_pkg and schp_move_plan.
module schp_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  schp_pkg::in_item_t  item,
	input  schp_pkg::cfg_t      cfg,
	output schp_pkg::res_t      res
);

	schp_pkg::mode_st_t         mode_q, mode_d;
	schp_pkg::dial_t            dial_q, dial_d;
	logic                       pol_q, pol_d;
	logic [schp_pkg::StepW-1:0] rem_q, rem_d;
	logic                       pa, pb, done;
	schp_pkg::plan_t            plan;
	logic [schp_pkg::RtcHourW-1:0] rtc_h12;

	schp_move_plan u_plan (
		.dial           (dial_q),
		.target_hours   (item.target_hours),
		.target_minutes (item.target_minutes),
		.cfg            (cfg),
		.plan           (plan)
	);

	// fold the 24-hour rtc hour onto the dial
	always_comb begin
		if (item.rtc_hours == '0)
			rtc_h12 = schp_pkg::RtcHourW'(12);
		else if (item.rtc_hours > schp_pkg::RtcHourW'(12))
			rtc_h12 = item.rtc_hours - schp_pkg::RtcHourW'(12);
		else
			rtc_h12 = item.rtc_hours;
	end

	// next state for the current word
	always_comb begin
		mode_d = mode_q;
		dial_d = dial_q;
		pol_d  = pol_q;
		rem_d  = rem_q;
		pa     = 1'b0;
		pb     = 1'b0;
		done   = 1'b0;
		case (item.op)
			schp_pkg::OP_MOVE: begin
				if (mode_q == schp_pkg::ST_READY) begin
					if (plan.at_target) begin
						done = 1'b1;
					end else if (plan.wait_rtc) begin
						mode_d = schp_pkg::ST_WAIT;
						rem_d  = '0;
					end else begin
						mode_d = schp_pkg::ST_MOVE;
						rem_d  = plan.fwd;
					end
				end
			end
			schp_pkg::OP_STEP: begin
				if (mode_q == schp_pkg::ST_MOVE) begin
					if (!cfg.motor_block) begin
						pa    = pol_q;
						pb    = !pol_q;
						pol_d = !pol_q;
					end
					// one minute forward, hour wraps 12 to 1
					if (dial_q.minutes == schp_pkg::MinW'(59)) begin
						dial_d.minutes = '0;
						dial_d.hours   = (dial_q.hours >= schp_pkg::HourW'(12)) ?
							schp_pkg::HourW'(1) : dial_q.hours + schp_pkg::HourW'(1);
					end else begin
						dial_d.minutes = dial_q.minutes + schp_pkg::MinW'(1);
					end
					if (rem_q != '0)
						rem_d = rem_q - schp_pkg::StepW'(1);
					if (rem_d == '0) begin
						mode_d = schp_pkg::ST_READY;
						done   = 1'b1;
					end
				end
			end
			schp_pkg::OP_RTC: begin
				if (mode_q == schp_pkg::ST_WAIT &&
				    rtc_h12 == {1'b0, dial_q.hours} && item.rtc_minutes == dial_q.minutes) begin
					mode_d = schp_pkg::ST_READY;
					done   = 1'b1;
				end
			end
			schp_pkg::OP_STOP: begin
				mode_d = schp_pkg::ST_STOP;
				rem_d  = '0;
			end
			schp_pkg::OP_START: begin
				if (mode_q == schp_pkg::ST_STOP)
					mode_d = schp_pkg::ST_READY;
			end
			default: ;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= schp_pkg::ST_READY;
			dial_q.hours   <= schp_pkg::HourRst;
			dial_q.minutes <= '0;
			pol_q          <= 1'b0;
			rem_q          <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			dial_q <= dial_d;
			pol_q  <= pol_d;
			rem_q  <= rem_d;
		end
	end

	// result word for this input word
	always_comb begin
		res.mode           = schp_pkg::mode_code(mode_d);
		res.pulse_a        = pa;
		res.pulse_b        = pb;
		res.dial_hours     = dial_d.hours;
		res.dial_minutes   = dial_d.minutes;
		res.pulse_polarity = pol_d;
		res.steps_left     = rem_d;
		res.move_done      = done;
	end

endmodule

>>> verif/testbench.sv
// Self-checking testbench for slave_clock_hand_positioner: directed words, then
// random move/step/rtc sequences under changing register settings and random stalls.
// Depends on schp_pkg and the RTL of the block; standalone otherwise.
`timescale 1ns / 100ps

module testbench;

	// one input word as the sender sees it
	typedef struct packed {
		logic [2:0]                    op;
		logic [schp_pkg::HourW-1:0]    th;
		logic [schp_pkg::MinW-1:0]     tm;
		logic [schp_pkg::RtcHourW-1:0] rh;
		logic [schp_pkg::MinW-1:0]     rm;
	} cmd_word_t;

	logic                         clk           = 1'b0;
	logic                         arst_n        = 1'b0;
	logic                         s_axis_tvalid = 1'b0;
	logic                         s_axis_tready;
	logic [23:0]                  s_axis_tdata  = '0;
	logic [2:0]                   s_axis_tuser  = '0;
	logic                         m_axis_tvalid;
	logic                         m_axis_tready = 1'b0;
	logic [31:0]                  m_axis_tdata;
	logic                         cfg_valid     = 1'b0;
	logic                         cfg_ready;
	logic [schp_pkg::CfgIdxW-1:0] cfg_index     = '0;
	logic [schp_pkg::MsW-1:0]     cfg_data      = '0;

	cmd_word_t       cmd_queue[$];
	schp_pkg::res_t  dial_results[$];
	bit              in_word_taken;
	int              fail_count    = 0;
	int              send_gap_pct  = 13;
	int              recv_gap_pct  = 13;
	int              hold_requests = 0;
	int              hold_seen     = 0;
	int              hold_left     = 0;

	// predicted dial state and register copies
	logic [1:0]                 dial_mode     = schp_pkg::MODE_READY;
	logic [schp_pkg::HourW-1:0] dial_hours    = schp_pkg::HourRst;
	logic [schp_pkg::MinW-1:0]  dial_minutes  = '0;
	logic                       dial_polarity = 1'b0;
	logic [schp_pkg::StepW-1:0] dial_steps    = '0;
	logic [schp_pkg::MsW-1:0]   pulse_len_ms  = schp_pkg::PulseMsRst;
	logic [schp_pkg::MsW-1:0]   pause_len_ms  = schp_pkg::AfterPulseMsRst;
	logic                       motor_blocked = 1'b0;

	slave_clock_hand_positioner i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// apply one word to the predicted dial and return the expected result
	function automatic schp_pkg::res_t position_hands(logic [2:0] op,
			logic [schp_pkg::HourW-1:0] th, logic [schp_pkg::MinW-1:0] tm,
			logic [schp_pkg::RtcHourW-1:0] rh, logic [schp_pkg::MinW-1:0] rm);
		int unsigned cur, tgt, fwd, back, hr;
		schp_pkg::res_t r;
		r = '0;
		case (op)
			schp_pkg::OP_MOVE: if (dial_mode == schp_pkg::MODE_READY) begin
				cur  = (dial_hours * schp_pkg::DialMin + dial_minutes) % schp_pkg::DialSpan;
				tgt  = (th * schp_pkg::DialMin + tm) % schp_pkg::DialSpan;
				fwd  = (tgt + schp_pkg::DialSpan - cur) % schp_pkg::DialSpan;
				back = (cur + schp_pkg::DialSpan - tgt) % schp_pkg::DialSpan;
				if (fwd == 0) begin
					r.move_done = 1'b1;
				end else if (back * schp_pkg::MsPerMin <=
				             fwd * (pulse_len_ms + pause_len_ms)) begin
					// cheaper to let real time catch up with the dial
					dial_mode  = schp_pkg::MODE_WAIT;
					dial_steps = '0;
				end else begin
					dial_mode  = schp_pkg::MODE_MOVE;
					dial_steps = schp_pkg::StepW'(fwd);
				end
			end
			schp_pkg::OP_STEP: if (dial_mode == schp_pkg::MODE_MOVE) begin
				if (!motor_blocked) begin
					r.pulse_a     = dial_polarity;
					r.pulse_b     = !dial_polarity;
					dial_polarity = !dial_polarity;
				end
				if (dial_minutes == 6'd59) begin
					dial_minutes = '0;
					dial_hours   = (dial_hours == 4'd12) ? 4'd1 : dial_hours + 4'd1;
				end else begin
					dial_minutes = dial_minutes + 6'd1;
				end
				if (dial_steps != 0)
					dial_steps = dial_steps - 1'b1;
				if (dial_steps == 0) begin
					dial_mode   = schp_pkg::MODE_READY;
					r.move_done = 1'b1;
				end
			end
			schp_pkg::OP_RTC: if (dial_mode == schp_pkg::MODE_WAIT) begin
				// fold 24-hour reading onto the dial
				hr = rh;
				if (hr == 0)
					hr = 12;
				if (hr > 12)
					hr = hr - 12;
				if (hr == dial_hours && rm == dial_minutes) begin
					dial_mode   = schp_pkg::MODE_READY;
					r.move_done = 1'b1;
				end
			end
			schp_pkg::OP_STOP: begin
				dial_mode  = schp_pkg::MODE_STOP;
				dial_steps = '0;
			end
			schp_pkg::OP_START: if (dial_mode == schp_pkg::MODE_STOP)
				dial_mode = schp_pkg::MODE_READY;
			default: ;
		endcase
		r.mode           = dial_mode;
		r.dial_hours     = dial_hours;
		r.dial_minutes   = dial_minutes;
		r.pulse_polarity = dial_polarity;
		r.steps_left     = dial_steps;
		return r;
	endfunction

	// input driver: next word from the queue, random gaps
	always @(negedge clk) begin
		cmd_word_t w;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || in_word_taken) begin
			if (cmd_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				w = cmd_queue.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {3'b000, w.rm, w.rh, w.tm, w.th};
				s_axis_tuser  <= w.op;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result receiver: random stalls plus requested long hold-offs
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = 60;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	// monitor: register writes, result check, then prediction of accepted words
	always @(posedge clk) begin
		schp_pkg::res_t want, got;
		in_word_taken = arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					schp_pkg::CFG_PULSE_MS:       pulse_len_ms  = cfg_data;
					schp_pkg::CFG_AFTER_PULSE_MS: pause_len_ms  = cfg_data;
					schp_pkg::CFG_MOTOR_BLOCK:    motor_blocked = cfg_data[0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.mode           = m_axis_tdata[1:0];
				got.pulse_a        = m_axis_tdata[2];
				got.pulse_b        = m_axis_tdata[3];
				got.dial_hours     = m_axis_tdata[7:4];
				got.dial_minutes   = m_axis_tdata[13:8];
				got.pulse_polarity = m_axis_tdata[14];
				got.steps_left     = m_axis_tdata[24:15];
				got.move_done      = m_axis_tdata[25];
				if (dial_results.size() == 0) begin
					$display("%0t: result word %h with nothing expected", $time, m_axis_tdata);
					fail_count++;
				end else begin
					want = dial_results.pop_front();
					if (got !== want || m_axis_tdata[31:26] !== '0) begin
						$display({"%0t: mismatch expected mode %0d a %0d b %0d %0d:%0d",
							" pol %0d left %0d done %0d"},
							$time, want.mode, want.pulse_a, want.pulse_b, want.dial_hours,
							want.dial_minutes, want.pulse_polarity, want.steps_left, want.move_done);
						$display({"%0t:          actual   mode %0d a %0d b %0d %0d:%0d",
							" pol %0d left %0d done %0d pad %h"},
							$time, got.mode, got.pulse_a, got.pulse_b, got.dial_hours,
							got.dial_minutes, got.pulse_polarity, got.steps_left, got.move_done,
							m_axis_tdata[31:26]);
						fail_count++;
					end
				end
			end
			if (in_word_taken)
				dial_results.push_back(position_hands(s_axis_tuser, s_axis_tdata[3:0],
					s_axis_tdata[9:4], s_axis_tdata[14:10], s_axis_tdata[20:15]));
		end
	end

	task automatic queue_cmd(logic [2:0] op, logic [schp_pkg::HourW-1:0] th,
			logic [schp_pkg::MinW-1:0] tm, logic [schp_pkg::RtcHourW-1:0] rh,
			logic [schp_pkg::MinW-1:0] rm, inout int counted, input bit counts);
		cmd_word_t w;
		w = '{op: op, th: th, tm: tm, rh: rh, rm: rm};
		cmd_queue.push_back(w);
		if (counts)
			counted++;
	endtask

	// a word the block drops in the current mode, random content
	task automatic queue_ignored(bit waiting, inout int counted);
		logic [2:0] op;
		case ($urandom_range(3))
			0: op = waiting ? schp_pkg::OP_STEP : schp_pkg::OP_RTC;
			1: op = schp_pkg::OP_MOVE;
			2: op = schp_pkg::OP_START;
			default: op = 3'($urandom_range(7, 5));
		endcase
		queue_cmd(op, 4'($urandom_range(15)), 6'($urandom_range(63)), 5'($urandom_range(31)),
			6'($urandom_range(63)), counted, 1'b0);
	endtask

	// any 24-hour reading that folds onto the given dial hour
	function automatic logic [schp_pkg::RtcHourW-1:0] rtc_for(logic [schp_pkg::HourW-1:0] h);
		logic [schp_pkg::RtcHourW-1:0] rh;
		if (h == 4'd12)
			rh = 5'(12 * $urandom_range(2));
		else
			rh = h + ($urandom_range(1) ? 5'd12 : 5'd0);
		return rh;
	endfunction

	// block until every word is sent and every result is back
	task automatic wait_idle();
		do begin
			@(posedge clk);
			#0.5;
		end while (cmd_queue.size() != 0 || s_axis_tvalid || dial_results.size() != 0);
	endtask

	task automatic write_reg(schp_pkg::cfg_idx_t idx, logic [schp_pkg::MsW-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int n_items, holds_done, setting, kind, cur, tgt, fwd, n, k, i, hr;
		logic [schp_pkg::HourW-1:0] th;
		logic [schp_pkg::MinW-1:0] tm;
		logic [schp_pkg::MsW-1:0] p, a;
		bit broken;
		n_items    = 0;
		holds_done = 0;
		setting    = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed words at reset settings, dial starts at 12:00
		queue_cmd(schp_pkg::OP_MOVE, 4'd12, 6'd0, 5'd0, 6'd0, n_items, 1'b1);  // already there
		queue_cmd(schp_pkg::OP_STEP, 4'd0, 6'd0, 5'd0, 6'd0, n_items, 1'b1);   // step when ready
		queue_cmd(schp_pkg::OP_RTC, 4'd0, 6'd0, 5'd0, 6'd0, n_items, 1'b1);    // rtc when ready
		queue_cmd(schp_pkg::OP_MOVE, 4'd0, 6'd3, 5'd0, 6'd0, n_items, 1'b1);   // hour 0, 3 steps
		queue_cmd(schp_pkg::OP_MOVE, 4'd5, 6'd10, 5'd0, 6'd0, n_items, 1'b1);  // move while moving
		queue_cmd(schp_pkg::OP_RTC, 4'd0, 6'd0, 5'd12, 6'd0, n_items, 1'b1);   // rtc while moving
		repeat (3) queue_cmd(schp_pkg::OP_STEP, 4'd0, 6'd0, 5'd0, 6'd0, n_items, 1'b1);
		queue_cmd(schp_pkg::OP_MOVE, 4'd12, 6'd1, 5'd0, 6'd0, n_items, 1'b1);  // short back: wait
		queue_cmd(schp_pkg::OP_RTC, 4'd0, 6'd0, 5'd23, 6'd59, n_items, 1'b1);  // no match
		queue_cmd(schp_pkg::OP_STEP, 4'd0, 6'd0, 5'd0, 6'd0, n_items, 1'b1);   // step while waiting
		queue_cmd(schp_pkg::OP_RTC, 4'd0, 6'd0, 5'd31, 6'd63, n_items, 1'b1);  // max fields
		queue_cmd(schp_pkg::OP_RTC, 4'd0, 6'd0, 5'd24, 6'd3, n_items, 1'b1);   // 24 folds to 12
		queue_cmd(schp_pkg::OP_MOVE, 4'd15, 6'd63, 5'd0, 6'd0, n_items, 1'b1); // out-of-range
		queue_cmd(schp_pkg::OP_STEP, 4'd0, 6'd0, 5'd0, 6'd0, n_items, 1'b1);
		queue_cmd(schp_pkg::OP_STOP, 4'd0, 6'd0, 5'd0, 6'd0, n_items, 1'b1);   // abort move
		queue_cmd(schp_pkg::OP_MOVE, 4'd1, 6'd0, 5'd0, 6'd0, n_items, 1'b1);   // move while stopped
		queue_cmd(schp_pkg::OP_STEP, 4'd0, 6'd0, 5'd0, 6'd0, n_items, 1'b1);
		queue_cmd(3'd5, 4'd15, 6'd63, 5'd31, 6'd63, n_items, 1'b1);   // unused codes
		queue_cmd(3'd6, 4'd0, 6'd0, 5'd0, 6'd0, n_items, 1'b1);
		queue_cmd(3'd7, 4'd10, 6'd42, 5'd21, 6'd21, n_items, 1'b1);
		queue_cmd(schp_pkg::OP_START, 4'd0, 6'd0, 5'd0, 6'd0, n_items, 1'b1);
		queue_cmd(schp_pkg::OP_START, 4'd0, 6'd0, 5'd0, 6'd0, n_items, 1'b1);  // start when ready
		queue_cmd(schp_pkg::OP_STOP, 4'd0, 6'd0, 5'd0, 6'd0, n_items, 1'b1);
		queue_cmd(schp_pkg::OP_START, 4'd0, 6'd0, 5'd0, 6'd0, n_items, 1'b1);
		n_items = 0;

		// random sequences, register setting changes every 250 words
		while (n_items < 2000) begin
			wait_idle();
			if (n_items >= setting * 250) begin
				case (setting % 8)
					0: begin p = 16'd4000;  a = 16'd0;     end
					1: begin p = 16'd1;     a = 16'd0;     end
					2: begin p = 16'hFFFF;  a = 16'hFFFF;  end
					3: begin p = 16'd1;     a = 16'hFFFF;  end
					4: begin p = 16'hFFFF;  a = 16'd0;     end
					5: begin p = 16'd1000;  a = 16'd500;   end
					default: begin
						p = 16'($urandom_range(65535, 1));
						a = 16'($urandom_range(65535));
					end
				endcase
				write_reg(schp_pkg::CFG_PULSE_MS, p);
				write_reg(schp_pkg::CFG_AFTER_PULSE_MS, a);
				write_reg(schp_pkg::CFG_MOTOR_BLOCK, (setting % 8 == 3 || setting % 8 == 4 ||
					setting % 8 == 7) ? 16'd1 : 16'd0);
				setting++;
			end
			// a stretch with no idling on either side
			send_gap_pct = (n_items >= 900 && n_items < 1200) ? 0 : 13;
			recv_gap_pct = send_gap_pct;

			// bring the dial back to ready first
			if (dial_mode != schp_pkg::MODE_READY) begin
				if (dial_mode != schp_pkg::MODE_STOP)
					queue_cmd(schp_pkg::OP_STOP, 4'($urandom_range(15)), 6'($urandom_range(63)),
						5'($urandom_range(31)), 6'($urandom_range(63)), n_items, 1'b1);
				queue_cmd(schp_pkg::OP_START, 4'($urandom_range(15)), 6'($urandom_range(63)),
					5'($urandom_range(31)), 6'($urandom_range(63)), n_items, 1'b1);
				wait_idle();
			end

			kind = $urandom_range(99);
			if (kind < 12) begin
				// noise: any words at all
				repeat ($urandom_range(6, 1))
					queue_cmd(3'($urandom_range(7)), 4'($urandom_range(15)),
						6'($urandom_range(63)), 5'($urandom_range(31)),
						6'($urandom_range(63)), n_items, 1'b1);
				continue;
			end

			// move command, target mostly near the dial
			cur = (dial_hours * schp_pkg::DialMin + dial_minutes) % schp_pkg::DialSpan;
			if (kind < 22) begin
				th = 4'($urandom_range(15));
				tm = 6'($urandom_range(63));
			end else begin
				fwd = (kind < 70) ? $urandom_range(40, 1) :
					schp_pkg::DialSpan - $urandom_range(30, 1);
				tgt = (cur + fwd) % schp_pkg::DialSpan;
				hr  = tgt / schp_pkg::DialMin;
				th  = 4'(hr);
				if (hr == 0 && $urandom_range(1))
					th = 4'd12;
				if (hr <= 3 && $urandom_range(1))
					th = 4'(hr + 12);
				tm = 6'(tgt % schp_pkg::DialMin);
			end
			queue_cmd(schp_pkg::OP_MOVE, th, tm, 5'($urandom_range(31)),
				6'($urandom_range(63)), n_items, 1'b1);
			wait_idle();

			broken = ($urandom_range(99) < 10);
			if (dial_mode == schp_pkg::MODE_MOVE) begin
				n = dial_steps;
				k = $urandom_range(n - 1);
				for (i = 0; i < n; i++) begin
					if ($urandom_range(99) < 8)
						queue_ignored(1'b0, n_items);
					if (broken && i == k) begin
						queue_cmd(schp_pkg::OP_STOP, 4'd0, 6'd0, 5'd0, 6'd0, n_items, 1'b1);
						if ($urandom_range(1))
							queue_cmd(schp_pkg::OP_START, 4'd0, 6'd0, 5'd0, 6'd0, n_items, 1'b1);
						break;
					end
					queue_cmd(schp_pkg::OP_STEP, 4'($urandom_range(15)), 6'($urandom_range(63)),
						5'($urandom_range(31)), 6'($urandom_range(63)), n_items, 1'b1);
				end
				// long receiver hold-off while steps keep coming
				if (n >= 20 && holds_done < 3 && n_items > 300) begin
					hold_requests++;
					holds_done++;
				end
			end else if (dial_mode == schp_pkg::MODE_WAIT) begin
				repeat ($urandom_range(4)) begin
					queue_cmd(schp_pkg::OP_RTC, 4'd0, 6'd0, 5'($urandom_range(31)),
						6'($urandom_range(63)), n_items, 1'b1);
					if ($urandom_range(99) < 20)
						queue_ignored(1'b1, n_items);
				end
				if (broken)
					queue_cmd(schp_pkg::OP_STOP, 4'd0, 6'd0, 5'd0, 6'd0, n_items, 1'b1);
				else
					queue_cmd(schp_pkg::OP_RTC, 4'($urandom_range(15)), 6'($urandom_range(63)),
						rtc_for(dial_hours), dial_minutes, n_items, 1'b1);
			end
		end

		wait_idle();
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("slave_clock_hand_positioner verification clean");
		else
			$display("slave_clock_hand_positioner verification failed");
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("slave_clock_hand_positioner verification failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hdl
hdl/schp_pkg.sv
hdl/schp_cfg_regs.sv
hdl/schp_move_plan.sv
hdl/schp_core.sv
hdl/slave_clock_hand_positioner.sv
verif/testbench.sv
